// File: hdl/mktx_pkg.sv
package mktx_pkg;

    // Width of the profit field and of the trade-count register.
    localparam int PROFIT_W = 20;
    localparam int PROFIT_MAX = (1 << PROFIT_W) - 1;
    localparam int K_W = 5;
    localparam logic [K_W-1:0] K_RESET = 5'd1;

    // APB register map: register index is taken from paddr[2].
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_MAX_TRANSACTIONS = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_STEP   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

// File: hdl/mktx_ctrl.sv
module mktx_ctrl #(
    parameter int MAX_TRADES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    output logic                          result_valid,
    input  logic                          result_ready,
    input  logic [$clog2(MAX_TRADES+1)-1:0] k,
    input  mktx_pkg::dp_status_t          status,
    output mktx_pkg::ctrl_cmd_t           cmd,
    output logic [((MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1)-1:0] slot
);
    import mktx_pkg::*;

    localparam int KW = $clog2(MAX_TRADES + 1);
    localparam int SW = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;

    state_t          state_reg, state_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic            result_valid_reg, result_valid_next;
    logic            accept;
    logic            last_slot;
    logic            out_free;

    assign item_ready   = (state_reg == ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign last_slot    = ((KW'(slot_reg) + KW'(1)) == k);
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign slot         = slot_reg;

    always_comb
    begin
        state_next        = state_reg;
        slot_next         = slot_reg;
        cmd               = '0;
        result_valid_next = result_ready ? 1'b0 : result_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    slot_next   = '0;
                    if (k != '0)
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                if (last_slot)
                begin
                    state_next = status.last ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                end
            end
            ST_FINISH:
            begin
                if (!status.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.finish        = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            slot_reg         <= slot_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// File: hdl/mktx_dp.sv
module mktx_dp #(
    parameter int MAX_TRADES = 16,
    parameter int PRICE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [PRICE_BITS-1:0]         price,
    input  logic                          last,
    input  mktx_pkg::ctrl_cmd_t           cmd,
    input  logic [((MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1)-1:0] slot,
    output mktx_pkg::dp_status_t          status,
    output logic [mktx_pkg::PROFIT_W-1:0] profit
);
    import mktx_pkg::*;

    localparam int KW = $clog2(MAX_TRADES + 1);
    localparam int SW = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;
    localparam int WS = PRICE_BITS + KW;
    localparam int WH = WS + 1;
    localparam int CW = (WS > PROFIT_W) ? WS : PROFIT_W;
    localparam logic signed [WH-1:0] HOLD_NONE = {1'b1, {(WH-1){1'b0}}};

    logic signed [WH-1:0]     hold_mem [MAX_TRADES];
    logic [WS-1:0]            sold_mem [MAX_TRADES];
    logic [MAX_TRADES-1:0]    valid_reg;

    logic signed [WH-1:0]     hold_rd_reg;
    logic [WS-1:0]            sold_rd_reg;
    logic                     valid_rd_reg;
    logic [SW-1:0]            rd_addr;

    logic [PRICE_BITS-1:0]    price_reg;
    logic                     last_reg;
    logic [WS-1:0]            prev_sold_reg, prev_sold_next;
    logic [PROFIT_W-1:0]      profit_reg;

    logic signed [WH-1:0]     hold_cur, buy, hold_new;
    logic [WS-1:0]            sold_cur, sold_new;
    logic signed [WH:0]       sell, sold_ext;
    logic [CW-1:0]            profit_wide;

    // Slot 0 is read while idle so that its data is ready for the first step.
    always_comb
    begin
        if (!cmd.step || (32'(slot) == MAX_TRADES - 1))
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = slot + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        hold_rd_reg <= hold_mem[rd_addr];
        sold_rd_reg <= sold_mem[rd_addr];
        if (cmd.step)
        begin
            hold_mem[slot] <= hold_new;
            sold_mem[slot] <= sold_new;
        end
    end

    // An entry that has not been written since the last clear reads as its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            valid_rd_reg <= 1'b0;
        end
        else
        begin
            valid_rd_reg <= valid_reg[rd_addr] && !cmd.finish;
            if (cmd.finish)
            begin
                valid_reg <= '0;
            end
            else if (cmd.step)
            begin
                valid_reg[slot] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        hold_cur = valid_rd_reg ? hold_rd_reg : HOLD_NONE;
        sold_cur = valid_rd_reg ? sold_rd_reg : '0;
        buy      = $signed({1'b0, prev_sold_reg})
                 - $signed({{(WH-PRICE_BITS){1'b0}}, price_reg});
        hold_new = (buy > hold_cur) ? buy : hold_cur;
        sell     = $signed({hold_new[WH-1], hold_new})
                 + $signed({{(WH+1-PRICE_BITS){1'b0}}, price_reg});
        sold_ext = $signed({2'b00, sold_cur});
        sold_new = (sell > sold_ext) ? sell[WS-1:0] : sold_cur;
    end

    always_comb
    begin
        prev_sold_next = prev_sold_reg;
        if (cmd.capture)
        begin
            prev_sold_next = '0;
        end
        else if (cmd.step)
        begin
            prev_sold_next = sold_new;
        end
    end

    assign profit_wide = CW'(prev_sold_reg);

    always_ff @(posedge clk)
    begin
        prev_sold_reg <= prev_sold_next;
        if (cmd.capture)
        begin
            price_reg <= price;
            last_reg  <= last;
        end
        if (cmd.finish)
        begin
            if (profit_wide > CW'(PROFIT_MAX))
            begin
                profit_reg <= PROFIT_W'(PROFIT_MAX);
            end
            else
            begin
                profit_reg <= profit_wide[PROFIT_W-1:0];
            end
        end
    end

    assign status.last = last_reg;
    assign profit      = profit_reg;

endmodule

// File: hdl/max_profit_k_transactions.sv
// Maximum profit from at most K non-overlapping buy-then-sell trades.
//
// Prices arrive on the request channel (price, last; item_valid/item_ready),
// one request per time step, with last set on the final price of a sequence.
// After the last price one result (profit) is offered on result_valid/
// result_ready; earlier prices produce no result. K is the max_transactions
// register on the APB port (address 0), saturated to MAX_TRADES.
//
// Each request is stepped through the trade slots one per cycle, through a
// single compare-and-update unit and one read and one write port on the
// per-slot memories. A request without last frees the input once all K
// slots are stepped (passing through the finish state when K is zero). A
// last request then moves to the finish state, which registers its result
// and frees the input together once the output register is free.
//
// Reset sets K to 1, empties the output register and marks all slots as
// holding their initial values; the slots are cleared the same way after every
// last request. The result sits in an output register, so new requests
// are taken while it waits; only the next last request stalls if the
// receiver has still not taken the previous result.
module max_profit_k_transactions #(
    parameter int MAX_TRADES = 16,
    parameter int PRICE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mktx_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mktx_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mktx_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [PRICE_BITS-1:0]               price,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [mktx_pkg::PROFIT_W-1:0]       profit
);
    import mktx_pkg::*;

    localparam int KW = $clog2(MAX_TRADES + 1);
    localparam int SW = (MAX_TRADES > 1) ? $clog2(MAX_TRADES) : 1;

    logic [K_W-1:0]  max_transactions_reg, max_transactions_next;
    logic [KW-1:0]   k;
    logic [SW-1:0]   slot;
    ctrl_cmd_t       cmd;
    dp_status_t      status;
    logic            reg_sel;

    // Register 0 is selected by paddr[2] low; the two byte-offset bits are ignored.
    assign reg_sel = (paddr[2] == REG_MAX_TRANSACTIONS);
    assign pready  = 1'b1;

    always_comb
    begin
        max_transactions_next = max_transactions_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            max_transactions_next = pwdata[K_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_transactions_reg <= K_RESET;
        end
        else
        begin
            max_transactions_reg <= max_transactions_next;
        end
    end

    assign prdata = reg_sel ? APB_DATA_W'(max_transactions_reg) : '0;

    // Trade counts above the slot count are clamped to the slot count.
    assign k = (32'(max_transactions_reg) > MAX_TRADES) ? KW'(MAX_TRADES)
                                                        : KW'(max_transactions_reg);

    mktx_ctrl #(
        .MAX_TRADES (MAX_TRADES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .k            (k),
        .status       (status),
        .cmd          (cmd),
        .slot         (slot)
    );

    mktx_dp #(
        .MAX_TRADES (MAX_TRADES),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .price  (price),
        .last   (last),
        .cmd    (cmd),
        .slot   (slot),
        .status (status),
        .profit (profit)
    );

endmodule

// File: tb/profit_checker.sv
module profit_checker #(
    parameter int MAX_TRADES = 16,
    parameter int PRICE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mktx_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mktx_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [mktx_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    input  logic                                item_valid,
    input  logic                                item_ready,
    input  logic [PRICE_BITS-1:0]               price,
    input  logic                                last,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [mktx_pkg::PROFIT_W-1:0]       profit,
    output int                                  mismatches,
    output int                                  pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import mktx_pkg::*;

    localparam int HOLD_W = 22;
    localparam int SOLD_W = 21;
    // Lies below any cash value that a buy can reach.
    localparam logic signed [HOLD_W-1:0] HOLD_NONE = {1'b1, {(HOLD_W-1){1'b0}}};

    logic [K_W-1:0]             trade_limit;
    logic signed [HOLD_W-1:0]   hold_cash [MAX_TRADES];
    logic signed [SOLD_W-1:0]   sold_cash [MAX_TRADES];
    logic [PROFIT_W-1:0]        expected_profit [$];
    logic [PROFIT_W-1:0]        want;

    function automatic void clear_slots();
        for (int t = 0; t < MAX_TRADES; t++)
        begin
            hold_cash[t] = HOLD_NONE;
            sold_cash[t] = '0;
        end
    endfunction

    // Steps every active trade slot for one price; the last price of a
    // sequence yields the expected profit and empties the slots.
    function automatic void take_price(input logic [PRICE_BITS-1:0] p, input logic is_last);
        int pv;
        int trades;
        int prev_sold;
        int buy;
        int sell;
        int best;
        pv = int'(p);
        trades = (int'(trade_limit) > MAX_TRADES) ? MAX_TRADES : int'(trade_limit);
        prev_sold = 0;
        for (int t = 0; t < trades; t++)
        begin
            buy = prev_sold - pv;
            if (buy > hold_cash[t])
                hold_cash[t] = HOLD_W'(buy);
            sell = hold_cash[t] + pv;
            if (sell > sold_cash[t])
                sold_cash[t] = SOLD_W'(sell);
            prev_sold = sold_cash[t];
        end
        if (is_last)
        begin
            best = (trades > 0) ? sold_cash[trades-1] : 0;
            if (best < 0)
                best = 0;
            if (best > PROFIT_MAX)
                best = PROFIT_MAX;
            expected_profit = {expected_profit, best[PROFIT_W-1:0]};
            clear_slots();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trade_limit = K_RESET;
            clear_slots();
            expected_profit.delete();
            pending_results = 0;
            mismatches = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_MAX_TRANSACTIONS)
            begin
                if (pwrite)
                    trade_limit = pwdata[K_W-1:0];
                else if (prdata[K_W-1:0] !== trade_limit)
                begin
                    $display("%0t: max_transactions read back: expected %0d, got %0d",
                             $time, trade_limit, prdata[K_W-1:0]);
                    mismatches++;
                end
            end
            // Results are retired before requests are taken, since a result
            // leaving at this edge can never belong to a request arriving now.
            if (result_valid && result_ready)
            begin
                if (expected_profit.size() == 0)
                begin
                    $display("%0t: profit: expected no result, got %0d", $time, profit);
                    mismatches++;
                end
                else
                begin
                    want = expected_profit.pop_front();
                    if (profit !== want)
                    begin
                        $display("%0t: profit: expected %0d, got %0d", $time, want, profit);
                        mismatches++;
                    end
                end
            end
            if (item_valid && item_ready)
                take_price(price, last);
            pending_results = expected_profit.size();
        end
    end

endmodule

// File: tb/max_profit_k_transactions_tb.sv
module max_profit_k_transactions_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mktx_pkg::*;

    localparam int MAX_TRADES = 16;
    localparam int PRICE_BITS = 16;
    localparam logic [PRICE_BITS-1:0] PRICE_TOP = '1;

    // After the last result has arrived the block may still be stepping a
    // request with no result; this settle wait lets it finish.
    localparam int IDLE_SETTLE = MAX_TRADES + 4;

    localparam int PHASES = 10;
    localparam int PHASE_REQUESTS = 112;
    localparam int MAX_GAP = 8;

    // The register index is taken from paddr[2]; the other index decodes to
    // nothing and writes to it must be dropped.
    localparam logic [APB_ADDR_W-1:0] ADDR_K = {REG_MAX_TRANSACTIONS, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_SPARE = {~REG_MAX_TRANSACTIONS, 2'b00};

    // Shapes of a random price sequence.
    typedef enum int {
        SHAPE_NOISE,
        SHAPE_ZIGZAG,
        SHAPE_FULL_ZIGZAG,
        SHAPE_WALK,
        SHAPE_LONG
    } shape_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       item_valid;
    logic                       item_ready;
    logic [PRICE_BITS-1:0]      price;
    logic                       last;
    logic                       result_valid;
    logic                       result_ready;
    logic [PROFIT_W-1:0]        profit;

    int                         mismatches;
    int                         pending_results;

    // When clear, both the request sender and the result receiver run flat
    // out, so that back-to-back traffic is exercised as well as gappy traffic.
    bit                         pacing;

    max_profit_k_transactions #(
        .MAX_TRADES (MAX_TRADES),
        .PRICE_BITS (PRICE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .price        (price),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .profit       (profit)
    );

    // The checker watches both channels and the register port, predicts every
    // profit and compares; this module only drives the block and decides.
    profit_checker #(
        .MAX_TRADES (MAX_TRADES),
        .PRICE_BITS (PRICE_BITS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .price           (price),
        .last            (last),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .profit          (profit),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Builds a register word whose unused upper bits carry random noise, so
    // that every bit of pwdata is toggled and the block must ignore them.
    function automatic logic [APB_DATA_W-1:0] reg_word(input logic [K_W-1:0] k);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[K_W-1:0] = k;
        return word;
    endfunction

    // One APB transfer: a setup cycle then an access cycle. Everything is
    // changed on the falling edge, so the block sees stable values at the
    // rising edge on which the transfer completes. The bus then idles before
    // the next transfer may start.
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one price request and holds it until the block takes it. Valid
    // is only lowered when a gap is drawn, so a request that follows straight
    // on keeps valid high without a lower-and-raise in the same time step.
    task automatic send_price(input logic [PRICE_BITS-1:0] p, input logic is_last);
        int gap;
        gap = pacing ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        price <= p;
        last <= is_last;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    // Stops offering requests and waits for every expected profit to arrive,
    // then lets the block finish any request that carries no result. Register
    // writes are only made after this, while the block is idle.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (IDLE_SETTLE) @(negedge clk);
    endtask

    // Sends one whole sequence of the given shape, ending with a last request.
    // Noise hits every price bit; the zigzags swing between the extremes, and
    // the full zigzag runs to about twice the slot count, so that it can fill
    // all trade slots and reach the largest profit; the walk gives the gentle
    // trends where many small trades compete with a few large ones.
    task automatic run_sequence(input shape_t shape, output int sent);
        int len;
        int walk;
        logic high;
        logic [PRICE_BITS-1:0] p;
        case (shape)
            SHAPE_FULL_ZIGZAG: len = $urandom_range(2 * MAX_TRADES - 2, 2 * MAX_TRADES + 2);
            SHAPE_LONG:        len = $urandom_range(25, 48);
            default:           len = $urandom_range(1, 24);
        endcase
        walk = $urandom_range(0, 65535);
        high = (shape == SHAPE_FULL_ZIGZAG) ? 1'b0 : 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_ZIGZAG, SHAPE_FULL_ZIGZAG:
                begin
                    p = high ? PRICE_TOP : '0;
                    high = ~high;
                end
                SHAPE_WALK:
                begin
                    walk = walk + int'($urandom_range(0, 512)) - 256;
                    if (walk < 0)
                        walk = 0;
                    if (walk > 65535)
                        walk = 65535;
                    p = PRICE_BITS'(walk);
                end
                default:
                    p = PRICE_BITS'($urandom);
            endcase
            send_price(p, i == len - 1);
        end
        sent = len;
    endtask

    // Results are taken with a random stall before each one. The receiver
    // raises ready independently of valid, and keeps it high across results
    // when no stall is drawn.
    initial
    begin
        int stall;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pacing ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready));
            @(negedge clk);
        end
    end

    // Main stimulus: reset, a short directed part, then random phases, each
    // under its own trade limit, and finally the verdict.
    initial
    begin
        logic [K_W-1:0] fixed_k [6];
        logic [K_W-1:0] k;
        shape_t shape;
        int pick;
        int sent;
        int count;

        // Limits chosen to hit the full slot count, two trades, the saturating
        // values above it, no trades at all and a single trade.
        fixed_k = '{5'd16, 5'd2, 5'd17, 5'd0, 5'd1, 5'd31};

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        price = '0;
        last = 1'b0;
        pacing = 1'b1;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The trade limit must come out of reset as one.
        apb_access(1'b0, ADDR_K, '0);

        // A sequence of a single price has nothing to sell into.
        send_price('0, 1'b1);
        // One trade from the bottom to the top of the price range.
        send_price(PRICE_TOP, 1'b0);
        send_price('0, 1'b0);
        send_price(PRICE_TOP, 1'b1);
        // Falling prices leave no profit.
        send_price(PRICE_TOP, 1'b0);
        send_price('0, 1'b1);
        wait_drained();

        // With no trades allowed, even a clear rise gives nothing.
        apb_access(1'b1, ADDR_K, reg_word(5'd0));
        send_price('0, 1'b0);
        send_price(PRICE_TOP, 1'b1);
        wait_drained();

        // A limit beyond the slot count saturates; a write to the unmapped
        // index must leave it alone, which the read-back confirms.
        apb_access(1'b1, ADDR_K, reg_word(5'd31));
        apb_access(1'b1, ADDR_SPARE, reg_word(5'd0));
        apb_access(1'b0, ADDR_K, '0);
        for (int i = 0; i < 6; i++)
            send_price((i % 2 == 1) ? PRICE_TOP : '0, i == 5);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            k = (ph < 6) ? fixed_k[ph] : 5'($urandom_range(0, 31));
            // Every fourth phase runs without any gaps on either side.
            pacing = (ph % 4 != 2);
            apb_access(1'b1, ADDR_K, reg_word(k));
            apb_access(1'b0, ADDR_K, '0);
            count = 0;
            while (count < PHASE_REQUESTS)
            begin
                pick = $urandom_range(0, 9);
                if (ph == 0 && count == 0)
                    shape = SHAPE_FULL_ZIGZAG;
                else if (pick < 5)
                    shape = SHAPE_NOISE;
                else if (pick == 5)
                    shape = SHAPE_ZIGZAG;
                else if (pick == 6)
                    shape = SHAPE_FULL_ZIGZAG;
                else if (pick < 9)
                    shape = SHAPE_WALK;
                else
                    shape = SHAPE_LONG;
                run_sequence(shape, sent);
                count += sent;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guards against a hang: far beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
